// ===== rtl/core/tvsm_pkg.sv =====
// Shared types, constants and tables for the thrust vector servo mixer.
// No dependencies.
package tvsm_pkg;

  localparam int unsigned CORDIC_ITERATIONS = 16;
  localparam int unsigned TAB_LEN           = 24;
  localparam int unsigned CORDIC_STEPS      =
      (CORDIC_ITERATIONS > TAB_LEN) ? TAB_LEN : CORDIC_ITERATIONS;

  localparam int unsigned ANG_FRAC = 16;
  localparam int unsigned VEC_W    = 40;
  localparam int unsigned ACC_W    = 26;

  localparam int unsigned SQRT_STAGES    = 32;
  localparam int unsigned DIV_STAGES     = 32;
  localparam int unsigned POS_DIV_STAGES = 8;

  localparam int unsigned LAT_SPEED = 3 + SQRT_STAGES + DIV_STAGES + 1;
  localparam int unsigned LAT_ANGLE = 3 + CORDIC_STEPS + POS_DIV_STAGES;
  localparam int unsigned LAT       = LAT_SPEED;
  localparam int unsigned ANGLE_PAD = LAT_SPEED - LAT_ANGLE;

  localparam logic signed [ACC_W-1:0] DEG45  = ACC_W'(45 * 65536);
  localparam logic signed [ACC_W-1:0] DEG90  = ACC_W'(90 * 65536);
  localparam logic signed [ACC_W-1:0] DEG135 = ACC_W'(135 * 65536);
  localparam logic signed [ACC_W-1:0] DEG180 = ACC_W'(180 * 65536);

  localparam logic signed [ACC_W-1:0] ATAN_TAB [TAB_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_THRUST      = 2'd0,
    REG_MAX_PROP_SPEED  = 2'd1,
    REG_MAX_SERVO_ANGLE = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] max_thrust;
    logic [15:0] max_prop_speed;
    logic [7:0]  max_servo_angle;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  left_pos;
    logic [7:0]  right_pos;
    logic [7:0]  rear_pos;
    logic [7:0]  front_pos;
    logic [15:0] prop_speed;
  } res_t;

endpackage

// ===== rtl/core/tvsm_speed.sv =====
// Propeller speed pipeline: squares, 32x32 product, digit-serial root and
// restoring divide stages, one stage each. Depends on tvsm_pkg.
module tvsm_speed import tvsm_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] fx_i,
  input  logic signed [15:0] fy_i,
  input  logic signed [15:0] fz_i,
  input  cfg_t               cfg_i,
  output logic [15:0]        speed_o
);

  logic signed [31:0] px, py, pz;
  logic [30:0] sx_q, sy_q, sz_q;
  logic [31:0] pp_q, pp2_q, s_q;
  logic [63:0] spp_q;
  logic        z3_q;

  assign px = fx_i * fx_i;
  assign py = fy_i * fy_i;
  assign pz = fz_i * fz_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q  <= px[30:0];
      sy_q  <= py[30:0];
      sz_q  <= pz[30:0];
      pp_q  <= 32'(cfg_i.max_prop_speed) * 32'(cfg_i.max_prop_speed);
      s_q   <= 32'(sx_q) + 32'(sy_q) + 32'(sz_q);
      pp2_q <= pp_q;
      spp_q <= 64'(s_q) * 64'(pp2_q);
      z3_q  <= (s_q == '0);
    end
  end

  logic [63:0] sq_rem [SQRT_STAGES+1];
  logic [63:0] sq_res [SQRT_STAGES+1];
  logic        sq_z   [SQRT_STAGES+1];

  assign sq_rem[0] = spp_q;
  assign sq_res[0] = '0;
  assign sq_z[0]   = z3_q;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'(1) << (2 * (SQRT_STAGES - 1 - k));
    logic [64:0] t;
    assign t = 65'(sq_res[k]) + 65'(Bit);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_z[k+1] <= sq_z[k];
        if (65'(sq_rem[k]) >= t) begin
          sq_rem[k+1] <= sq_rem[k] - t[63:0];
          sq_res[k+1] <= (sq_res[k] >> 1) + Bit;
        end else begin
          sq_rem[k+1] <= sq_rem[k];
          sq_res[k+1] <= sq_res[k] >> 1;
        end
      end
    end
  end

  logic [31:0] dv_q [DIV_STAGES+1];
  logic [15:0] dr_q [DIV_STAGES+1];
  logic        dz_q [DIV_STAGES+1];

  assign dv_q[0] = sq_res[SQRT_STAGES][31:0];
  assign dr_q[0] = '0;
  assign dz_q[0] = sq_z[SQRT_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [16:0] r2;
    assign r2 = {dr_q[j], dv_q[j][31]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dz_q[j+1] <= dz_q[j];
        if (r2 >= {1'b0, cfg_i.max_thrust}) begin
          dr_q[j+1] <= 16'(r2 - {1'b0, cfg_i.max_thrust});
          dv_q[j+1] <= {dv_q[j][30:0], 1'b1};
        end else begin
          dr_q[j+1] <= r2[15:0];
          dv_q[j+1] <= {dv_q[j][30:0], 1'b0};
        end
      end
    end
  end

  logic [31:0] q;
  assign q = dv_q[DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (dz_q[DIV_STAGES]) begin
        speed_o <= '0;
      end else if (cfg_i.max_thrust == '0 || q > 32'(cfg_i.max_prop_speed)) begin
        speed_o <= cfg_i.max_prop_speed;
      end else begin
        speed_o <= q[15:0];
      end
    end
  end

endmodule

// ===== rtl/core/tvsm_angle.sv =====
// Vane angle pipeline: special cases, CORDIC vectoring stages, clamp,
// position scaling by a restoring divide, and latency padding. Uses tvsm_pkg.
module tvsm_angle import tvsm_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [16:0] num_i,
  input  logic signed [15:0] den_i,
  input  logic [7:0]         lim_i,
  output logic [7:0]         pos_o
);

  logic [16:0] an, ad;
  logic        num_pos, spec;
  logic signed [ACC_W-1:0] sval, tmp, base;
  logic signed [VEC_W-1:0] n0, d0;

  always_comb begin
    an      = num_i[16] ? 17'(-num_i) : 17'(num_i);
    ad      = den_i[15] ? 17'(-{den_i[15], den_i}) : {1'b0, den_i};
    num_pos = !num_i[16] && (num_i != '0);
    spec    = 1'b1;
    sval    = '0;
    tmp     = den_i[15] ? DEG135 : DEG45;
    if (num_i == '0) begin
      sval = den_i[15] ? DEG180 : '0;
    end else if (den_i == '0) begin
      sval = num_pos ? DEG90 : -DEG90;
    end else if (an == ad) begin
      sval = num_pos ? tmp : -tmp;
    end else begin
      spec = 1'b0;
    end
    n0   = {{(VEC_W-17-ANG_FRAC){num_i[16]}}, num_i, {ANG_FRAC{1'b0}}};
    d0   = {{(VEC_W-16-ANG_FRAC){den_i[15]}}, den_i, {ANG_FRAC{1'b0}}};
    base = '0;
    if (den_i[15]) begin
      n0   = -n0;
      d0   = -d0;
      base = num_pos ? DEG180 : -DEG180;
    end
  end

  logic signed [VEC_W-1:0] cn [CORDIC_STEPS+1];
  logic signed [VEC_W-1:0] cd [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0] ca [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0] cb [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0] cv [CORDIC_STEPS+1];
  logic                    cs [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cn[0] <= n0;
      cd[0] <= d0;
      ca[0] <= '0;
      cb[0] <= base;
      cv[0] <= sval;
      cs[0] <= spec;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
    logic signed [VEC_W-1:0] dn, dd;
    assign dn = cn[i] >>> i;
    assign dd = cd[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cb[i+1] <= cb[i];
        cv[i+1] <= cv[i];
        cs[i+1] <= cs[i];
        if (!cn[i][VEC_W-1] && cn[i] != '0) begin
          cn[i+1] <= cn[i] - dd;
          cd[i+1] <= cd[i] + dn;
          ca[i+1] <= ca[i] + ATAN_TAB[i];
        end else if (cn[i][VEC_W-1]) begin
          cn[i+1] <= cn[i] + dd;
          cd[i+1] <= cd[i] - dn;
          ca[i+1] <= ca[i] - ATAN_TAB[i];
        end else begin
          cn[i+1] <= cn[i];
          cd[i+1] <= cd[i];
          ca[i+1] <= ca[i];
        end
      end
    end
  end

  logic signed [ACC_W-1:0] sum, fa_q, mag;
  assign sum = ca[CORDIC_STEPS] + cb[CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cs[CORDIC_STEPS]) begin
        fa_q <= cv[CORDIC_STEPS];
      end else if (sum > DEG180) begin
        fa_q <= DEG180;
      end else if (sum <= -DEG180) begin
        fa_q <= -DEG180 + ACC_W'(1);
      end else begin
        fa_q <= sum;
      end
    end
  end

  logic [8:0]        dm;
  logic signed [9:0] deg, lim_s, degc;
  logic [9:0]        u;
  logic [17:0]       numer_q;

  always_comb begin
    mag   = fa_q[ACC_W-1] ? -fa_q : fa_q;
    dm    = mag[ANG_FRAC+8:ANG_FRAC];
    deg   = fa_q[ACC_W-1] ? -$signed({1'b0, dm}) : $signed({1'b0, dm});
    lim_s = $signed({2'b00, lim_i});
    degc  = deg;
    if (deg > lim_s) begin
      degc = lim_s;
    end else if (deg < -lim_s) begin
      degc = -lim_s;
    end
    u = 10'(degc + lim_s);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numer_q <= 18'(u) * 18'd180;
    end
  end

  logic [17:0] pr [POS_DIV_STAGES+1];
  logic [7:0]  pq [POS_DIV_STAGES+1];
  logic [8:0]  dvs;

  assign dvs   = {lim_i, 1'b0};
  assign pr[0] = numer_q;
  assign pq[0] = '0;

  for (genvar s = 0; s < POS_DIV_STAGES; s++) begin : g_pdiv
    logic [17:0] sh;
    assign sh = 18'(dvs) << (POS_DIV_STAGES - 1 - s);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (pr[s] >= sh) begin
          pr[s+1] <= pr[s] - sh;
          pq[s+1] <= {pq[s][6:0], 1'b1};
        end else begin
          pr[s+1] <= pr[s];
          pq[s+1] <= {pq[s][6:0], 1'b0};
        end
      end
    end
  end

  logic [7:0] pad_q [ANGLE_PAD];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pad_q[0] <= (lim_i == '0) ? 8'd90 : pq[POS_DIV_STAGES];
      for (int k = 1; k < ANGLE_PAD; k++) begin
        pad_q[k] <= pad_q[k-1];
      end
    end
  end

  assign pos_o = pad_q[ANGLE_PAD-1];

endmodule

// ===== rtl/core/tvsm_out.sv =====
// Output register with a one-beat skid stage; stalls the pipeline only
// when both are full. Depends on tvsm_pkg.
module tvsm_out import tvsm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic last_valid_i,
  input  res_t last_data_i,
  input  logic m_tready_i,
  output logic adv_o,
  output logic m_tvalid_o,
  output res_t m_data_o
);

  logic out_v_q, skid_v_q;
  res_t out_q, skid_q;

  assign adv_o      = !skid_v_q;
  assign m_tvalid_o = out_v_q;
  assign m_data_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_tready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= last_valid_i;
      end
    end else if (last_valid_i && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_tready_i) begin
      out_q <= skid_v_q ? skid_q : last_data_i;
    end else if (!skid_v_q) begin
      skid_q <= last_data_i;
    end
  end

endmodule

// ===== rtl/core/thrust_vector_servo_mixer.sv =====
// Thrust vector servo mixer: turns a Q8.8 force vector into a propeller
// speed and four vane servo positions. A new vector is taken every clock
// cycle unless the skid stage is full; the 32-stage square root and the
// 32-stage quotient of the speed path set the delay, and the vane angle path
// is padded to match. Stalls on the output hold the whole pipeline once the
// output register and its skid stage are full. Registers are to be written
// through the cfg port only while no beat is in flight; the block does not
// enforce this. Depends on tvsm_pkg, tvsm_speed, tvsm_angle and tvsm_out.
module thrust_vector_servo_mixer import tvsm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,  // force_x, force_y, force_z
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,  // prop_speed, front_pos, rear_pos,
                                              // right_pos, left_pos
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_thrust      <= 16'd256;
      cfg_q.max_prop_speed  <= 16'd1000;
      cfg_q.max_servo_angle <= 8'd45;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MAX_THRUST:      cfg_q.max_thrust      <= cfg_wdata_i;
        REG_MAX_PROP_SPEED:  cfg_q.max_prop_speed  <= cfg_wdata_i;
        REG_MAX_SERVO_ANGLE: cfg_q.max_servo_angle <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic [LAT-1:0] v_q;

  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[LAT-2:0], s_axis_tvalid};
    end
  end

  logic signed [15:0] fx, fy, fz;
  logic signed [16:0] nx, ny;
  res_t res;

  assign fx = s_axis_tdata[15:0];
  assign fy = s_axis_tdata[31:16];
  assign fz = s_axis_tdata[47:32];
  assign nx = -{fx[15], fx};
  assign ny = -{fy[15], fy};

  tvsm_speed u_speed (
    .clk_i   (clk_i),
    .en_i    (adv),
    .fx_i    (fx),
    .fy_i    (fy),
    .fz_i    (fz),
    .cfg_i   (cfg_q),
    .speed_o (res.prop_speed)
  );

  tvsm_angle u_front (
    .clk_i (clk_i), .en_i (adv), .num_i ({fx[15], fx}), .den_i (fz),
    .lim_i (cfg_q.max_servo_angle), .pos_o (res.front_pos)
  );

  tvsm_angle u_rear (
    .clk_i (clk_i), .en_i (adv), .num_i (nx), .den_i (fz),
    .lim_i (cfg_q.max_servo_angle), .pos_o (res.rear_pos)
  );

  tvsm_angle u_right (
    .clk_i (clk_i), .en_i (adv), .num_i ({fy[15], fy}), .den_i (fz),
    .lim_i (cfg_q.max_servo_angle), .pos_o (res.right_pos)
  );

  tvsm_angle u_left (
    .clk_i (clk_i), .en_i (adv), .num_i (ny), .den_i (fz),
    .lim_i (cfg_q.max_servo_angle), .pos_o (res.left_pos)
  );

  res_t out_data;

  tvsm_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .last_valid_i (v_q[LAT-1] && adv),
    .last_data_i  (res),
    .m_tready_i   (m_axis_tready),
    .adv_o        (adv),
    .m_tvalid_o   (m_axis_tvalid),
    .m_data_o     (out_data)
  );

  assign m_axis_tdata = out_data;

endmodule

// ===== tb/sv/tvsm_checker.sv =====
// Checker for the thrust vector servo mixer: predicts each result beat from
// the accepted force beat and the shadow register file, then compares.
// Depends on tvsm_pkg.
module tvsm_checker import tvsm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [47:0]          m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam longint ONE = 65536;

  cfg_t   shadow_cfg;
  res_t   expected_q[$];

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vane_angle(longint num, longint den);
    longint acc, base, n, d, dn, dd;
    acc = 0;
    base = 0;
    if (num == 0) return (den < 0) ? 180 * ONE : 0;
    if (den == 0) return (num > 0) ? 90 * ONE : -90 * ONE;
    if ((num < 0 ? -num : num) == (den < 0 ? -den : den)) begin
      acc = (den > 0) ? 45 * ONE : 135 * ONE;
      return (num > 0) ? acc : -acc;
    end
    n = num * ONE;
    d = den * ONE;
    if (d < 0) begin
      base = (num > 0) ? 180 * ONE : -180 * ONE;
      d = -d;
      n = -n;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dn = n >>> i;
      dd = d >>> i;
      if (n > 0) begin
        d = d + dn; n = n - dd; acc = acc + longint'(ATAN_TAB[i]);
      end else if (n < 0) begin
        d = d - dn; n = n + dd; acc = acc - longint'(ATAN_TAB[i]);
      end
    end
    acc = acc + base;
    if (acc > 180 * ONE) acc = 180 * ONE;
    if (acc <= -180 * ONE) acc = -180 * ONE + 1;
    return acc;
  endfunction

  function automatic logic [7:0] servo_position(longint num, longint den, cfg_t c);
    longint acc, deg, a;
    acc = vane_angle(num, den);
    deg = (acc >= 0) ? (acc >>> 16) : -((-acc) >>> 16);
    a = c.max_servo_angle;
    if (a == 0) return 8'd90;
    if (deg > a) deg = a;
    if (deg < -a) deg = -a;
    return 8'(((deg + a) * 180) / (2 * a));
  endfunction

  function automatic res_t mix_vector(logic [47:0] f, cfg_t c);
    res_t r;
    longint x, y, z, p, sp;
    longint unsigned s;
    x = longint'($signed(f[15:0]));
    y = longint'($signed(f[31:16]));
    z = longint'($signed(f[47:32]));
    p = c.max_prop_speed;
    s = x * x + y * y + z * z;
    if (s == 0) sp = 0;
    else if (c.max_thrust == 0) sp = p;
    else begin
      sp = isqrt(s * p * p) / c.max_thrust;
      if (sp > p) sp = p;
    end
    r.prop_speed = 16'(sp);
    r.front_pos  = servo_position(x, z, c);
    r.rear_pos   = servo_position(-x, z, c);
    r.right_pos  = servo_position(y, z, c);
    r.left_pos   = servo_position(-y, z, c);
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want, got;
    if (!rst_ni) begin
      shadow_cfg <= '{max_thrust: 16'd256, max_prop_speed: 16'd1000, max_servo_angle: 8'd45};
      errors_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_THRUST:      shadow_cfg.max_thrust <= cfg_wdata_i;
          REG_MAX_PROP_SPEED:  shadow_cfg.max_prop_speed <= cfg_wdata_i;
          REG_MAX_SERVO_ANGLE: shadow_cfg.max_servo_angle <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(mix_vector(s_axis_tdata, shadow_cfg));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result beat %h", m_axis_tdata);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (errors_o < 10)
              $display("mismatch: exp spd %0d f %0d r %0d rt %0d l %0d, got spd %0d f %0d r %0d rt %0d l %0d",
                       want.prop_speed, want.front_pos, want.rear_pos, want.right_pos,
                       want.left_pos, got.prop_speed, got.front_pos, got.rear_pos,
                       got.right_pos, got.left_pos);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/thrust_vector_servo_mixer_test.sv =====
// Testbench top for the thrust vector servo mixer: drives force beats and
// register writes under several idling phases and gives the verdict.
// Depends on tvsm_pkg, thrust_vector_servo_mixer and tvsm_checker.
module thrust_vector_servo_mixer_test;
  import tvsm_pkg::*;

  localparam int WATCHDOG = 4000;

  logic                 clk_i, rst_ni;
  logic                 s_axis_tvalid, s_axis_tready;
  logic [47:0]          s_axis_tdata;
  logic                 m_axis_tvalid, m_axis_tready;
  logic [47:0]          m_axis_tdata;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0]          cfg_wdata_i;
  int                   errors, pending, idle_cycles;
  int                   send_idle, recv_stall;

  thrust_vector_servo_mixer dut (.*);

  tvsm_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall);

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // tvalid stays up between back-to-back beats; idle cycles drop it
  task automatic send_force(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LAT + 10) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'($urandom_range(7)) - 16'd3;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'($urandom_range(2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] v;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_MAX_THRUST;
    cfg_wdata_i   = '0;
    send_idle     = 0;
    recv_stall    = 0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero, axes, diagonals, extremes
    send_force(16'd0, 16'd0, 16'd0);
    send_force(16'd0, 16'd0, 16'hff00);
    send_force(16'd0, 16'd0, 16'd256);
    send_force(16'd300, 16'hfed4, 16'd0);
    send_force(16'd500, 16'd500, 16'd500);
    send_force(16'd500, 16'hfe0c, 16'hfe0c);
    send_force(16'h7fff, 16'h8000, 16'h7fff);
    send_force(16'h8000, 16'h8000, 16'h8000);
    send_force(16'h7fff, 16'h7fff, 16'h8000);
    send_force(16'd1, 16'hffff, 16'd1000);
    send_force(16'd1000, 16'd7, 16'hfff0);
    send_force(16'hffff, 16'hffff, 16'hffff);
    drain();
    write_reg(REG_MAX_THRUST, 16'd1);
    write_reg(REG_MAX_PROP_SPEED, 16'hffff);
    write_reg(REG_MAX_SERVO_ANGLE, 16'd180);
    send_force(16'h7fff, 16'd0, 16'd5);
    send_force(16'd3, 16'd2, 16'hffff);
    send_force(16'd0, 16'h8000, 16'd0);
    drain();
    write_reg(REG_MAX_THRUST, 16'hffff);
    write_reg(REG_MAX_PROP_SPEED, 16'd0);
    write_reg(REG_MAX_SERVO_ANGLE, 16'd1);
    send_force(16'd100, 16'hff9c, 16'd50);
    send_force(16'h8000, 16'h7fff, 16'h8000);
    send_force(16'd0, 16'd0, 16'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 69; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 69; end
        default: begin send_idle = 17; recv_stall = 17; end
      endcase
      v = (ph == 7) ? 16'd256 : ((ph % 2) ? 16'hffff : 16'($urandom_range(1, 65535)));
      write_reg(REG_MAX_THRUST, v);
      write_reg(REG_MAX_PROP_SPEED, (ph == 2) ? 16'hffff : 16'($urandom));
      write_reg(REG_MAX_SERVO_ANGLE,
                (ph == 3) ? 16'd180 : (ph == 5) ? 16'd1 : 16'($urandom_range(1, 180)));
      for (int i = 0; i < 225; i++)
        send_force(rand_comp(), rand_comp(), rand_comp());
      drain();
    end

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
